>>> hdl/tpe_pkg.sv
// Shared types and widths for the triangle plane equation pipeline.
// No dependencies.
package tpe_pkg;

    localparam int CW   = 32;   // vertex coordinate
    localparam int EW   = 33;   // edge component
    localparam int PW   = 66;   // edge product
    localparam int XW   = 67;   // cross product component
    localparam int WW   = 31;   // scaled working component
    localparam int SQW  = 64;   // sum of squares
    localparam int RTW  = 32;   // square root
    localparam int QW   = 31;   // quotient magnitude
    localparam int NMW  = 62;   // dividend
    localparam int DW   = 40;   // plane offset

    typedef logic [2:0][CW-1:0] vert_t;
    typedef logic [2:0][WW-1:0] wvec_t;
    typedef logic [2:0][QW-1:0] qvec_t;

    typedef struct packed {
        logic [2:0] neg;
        vert_t      a;
        logic       degen;
    } side_t;

endpackage

>>> hdl/tpe_front.sv
// Front end: edge vectors, cross product, magnitude, bit length, scaling, sum of squares.
// Depends on tpe_pkg. Nine register stages.
module tpe_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  tpe_pkg::vert_t va,
    input  tpe_pkg::vert_t vb,
    input  tpe_pkg::vert_t vc,
    output logic           out_valid,
    output tpe_pkg::wvec_t w,
    output logic [63:0]    sumsq,
    output tpe_pkg::side_t side
);
    import tpe_pkg::*;

    logic [8:0]              vld_reg;
    vert_t                   a_pipe_reg [9];
    logic signed [EW-1:0]    e1_reg [3];
    logic signed [EW-1:0]    e2_reg [3];
    logic signed [PW-1:0]    p_reg [6];
    logic signed [XW-1:0]    cr_reg [3];
    logic [XW-1:0]           mag4_reg [3];
    logic [XW-1:0]           mag5_reg [3];
    logic [XW-1:0]           mag6_reg [3];
    logic [2:0]              neg_pipe_reg [6];
    logic [8:0]              nzb_reg;
    logic [2:0]              pos_reg [9];
    logic [6:0]              len6_reg;
    logic                    deg_pipe_reg [4];
    wvec_t                   w7_reg, w8_reg, w9_reg;
    logic [61:0]             sq_reg [3];
    logic [63:0]             sum_reg;

    logic [71:0]             mag_or;
    logic [8:0]              nzb_next;
    logic [2:0]              pos_next [9];
    logic [6:0]              len_next;
    wvec_t                   w_next;

    always_comb
    begin
        mag_or = {5'd0, mag4_reg[0] | mag4_reg[1] | mag4_reg[2]};
        for (int b = 0; b < 9; b++)
        begin
            nzb_next[b] = |mag_or[b*8 +: 8];
            pos_next[b] = 3'd0;
            for (int j = 0; j < 8; j++)
            begin
                if (mag_or[b*8 + j])
                begin
                    pos_next[b] = 3'(j);
                end
            end
        end
    end

    always_comb
    begin
        len_next = 7'd0;
        for (int b = 0; b < 9; b++)
        begin
            if (nzb_reg[b])
            begin
                len_next = 7'(b * 8) + {4'd0, pos_reg[b]} + 7'd1;
            end
        end
    end

    always_comb
    begin
        logic [97:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sh        = {mag6_reg[i], 31'd0} >> len6_reg;
            w_next[i] = sh[WW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_pipe_reg[0] <= va;
            for (int k = 1; k < 9; k++)
            begin
                a_pipe_reg[k] <= a_pipe_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= $signed({vb[i][CW-1], vb[i]}) - $signed({va[i][CW-1], va[i]});
                e2_reg[i] <= $signed({vc[i][CW-1], vc[i]}) - $signed({va[i][CW-1], va[i]});
            end
            p_reg[0] <= e1_reg[1] * e2_reg[2];
            p_reg[1] <= e1_reg[2] * e2_reg[1];
            p_reg[2] <= e1_reg[2] * e2_reg[0];
            p_reg[3] <= e1_reg[0] * e2_reg[2];
            p_reg[4] <= e1_reg[0] * e2_reg[1];
            p_reg[5] <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= $signed({p_reg[2*i][PW-1], p_reg[2*i]})
                           - $signed({p_reg[2*i+1][PW-1], p_reg[2*i+1]});
                neg_pipe_reg[0][i] <= cr_reg[i][XW-1];
                mag4_reg[i] <= cr_reg[i][XW-1] ? XW'(-cr_reg[i]) : XW'(cr_reg[i]);
                mag5_reg[i] <= mag4_reg[i];
                mag6_reg[i] <= mag5_reg[i];
                sq_reg[i]   <= 62'(w7_reg[i]) * 62'(w7_reg[i]);
            end
            for (int k = 1; k < 6; k++)
            begin
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
            end
            nzb_reg  <= nzb_next;
            pos_reg  <= pos_next;
            len6_reg <= len_next;
            deg_pipe_reg[0] <= (len_next == 7'd0);
            for (int k = 1; k < 4; k++)
            begin
                deg_pipe_reg[k] <= deg_pipe_reg[k-1];
            end
            w7_reg  <= w_next;
            w8_reg  <= w7_reg;
            w9_reg  <= w8_reg;
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        end
    end

    assign out_valid  = vld_reg[8];
    assign w          = w9_reg;
    assign sumsq      = sum_reg;
    assign side.neg   = neg_pipe_reg[5];
    assign side.a     = a_pipe_reg[8];
    assign side.degen = deg_pipe_reg[3];

endmodule

>>> hdl/tpe_sqrt.sv
// Pipelined integer square root, one result bit per stage, 32 stages.
// Depends on tpe_pkg.
module tpe_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  logic [63:0]    sumsq,
    input  tpe_pkg::wvec_t in_w,
    input  tpe_pkg::side_t in_side,
    output logic           out_valid,
    output logic [31:0]    root,
    output tpe_pkg::wvec_t out_w,
    output tpe_pkg::side_t out_side
);
    import tpe_pkg::*;

    logic [RTW-1:0] vld_reg;
    logic [SQW-1:0] rem_reg [RTW];
    logic [RTW-1:0] root_reg [RTW];
    wvec_t          w_reg [RTW];
    side_t          side_reg [RTW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[RTW-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < RTW; s++)
    begin : g_stage
        localparam int B = RTW - 1 - s;
        logic [SQW-1:0] rem_in;
        logic [RTW-1:0] root_in;
        wvec_t          w_in;
        side_t          side_in;
        logic [65:0]    trial;

        if (s == 0)
        begin : g_first
            assign rem_in  = sumsq;
            assign root_in = '0;
            assign w_in    = in_w;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign w_in    = w_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign trial = ({34'd0, root_in} << (B + 1)) | (66'd1 << (2 * B));

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if ({2'b00, rem_in} >= trial)
                begin
                    rem_reg[s]  <= rem_in - trial[SQW-1:0];
                    root_reg[s] <= root_in | (RTW'(1) << B);
                end
                else
                begin
                    rem_reg[s]  <= rem_in;
                    root_reg[s] <= root_in;
                end
                w_reg[s]    <= w_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[RTW-1];
    assign root      = root_reg[RTW-1];
    assign out_w     = w_reg[RTW-1];
    assign out_side  = side_reg[RTW-1];

endmodule

>>> hdl/tpe_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, 31 stages.
// Depends on tpe_pkg.
module tpe_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  logic [31:0]    len,
    input  tpe_pkg::wvec_t w,
    input  tpe_pkg::side_t in_side,
    output logic           out_valid,
    output tpe_pkg::qvec_t q,
    output tpe_pkg::side_t out_side
);
    import tpe_pkg::*;

    logic [QW-1:0]  vld_reg;
    logic [NMW-1:0] rem_reg [QW][3];
    logic [QW-1:0]  q_reg [QW][3];
    logic [RTW-1:0] len_reg [QW];
    side_t          side_reg [QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[QW-2:0], in_valid};
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int B = QW - 1 - s;
        logic [NMW-1:0] rem_in [3];
        logic [QW-1:0]  q_in [3];
        logic [RTW-1:0] len_in;
        side_t          side_in;
        logic [62:0]    dsh;

        if (s == 0)
        begin : g_first
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = {w[i], 30'd0} + NMW'(len >> 1);
                assign q_in[i]   = '0;
            end
            assign len_in  = len;
            assign side_in = in_side;
        end
        else
        begin : g_next
            for (genvar i = 0; i < 3; i++)
            begin : g_lane
                assign rem_in[i] = rem_reg[s-1][i];
                assign q_in[i]   = q_reg[s-1][i];
            end
            assign len_in  = len_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        assign dsh = {31'd0, len_in} << B;

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if ({1'b0, rem_in[i]} >= dsh)
                    begin
                        rem_reg[s][i] <= rem_in[i] - dsh[NMW-1:0];
                        q_reg[s][i]   <= q_in[i] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[s][i] <= rem_in[i];
                        q_reg[s][i]   <= q_in[i];
                    end
                end
                len_reg[s]  <= len_in;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign q[i] = q_reg[QW-1][i];
    end

endmodule

>>> hdl/tpe_back.sv
// Back end: signed normal, dot product with first vertex, rounding, output register.
// Depends on tpe_pkg. Four register stages.
module tpe_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           ce,
    input  logic           in_valid,
    input  tpe_pkg::qvec_t q,
    input  tpe_pkg::side_t side,
    output logic           out_valid,
    output logic [31:0]    normal_x,
    output logic [31:0]    normal_y,
    output logic [31:0]    normal_z,
    output logic [39:0]    plane_offset,
    output logic           degenerate
);
    import tpe_pkg::*;

    logic [3:0]           vld_reg;
    logic signed [31:0]   n1_reg [3];
    logic signed [31:0]   n2_reg [3];
    logic signed [31:0]   n3_reg [3];
    logic signed [63:0]   prod_reg [3];
    logic signed [63:0]   p_reg;
    logic                 deg_reg [3];
    vert_t                a_reg;
    logic [31:0]          nx_reg, ny_reg, nz_reg;
    logic [DW-1:0]        d_reg;
    logic                 dg_reg;

    logic [63:0]          pm;
    logic [63:0]          dm;
    logic [DW-1:0]        d_next;

    always_comb
    begin
        pm     = p_reg[63] ? 64'(-p_reg) : 64'(p_reg);
        dm     = (pm + 64'd536870912) >> 30;
        d_next = p_reg[63] ? dm[DW-1:0] : DW'(-dm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_reg <= side.a;
            for (int i = 0; i < 3; i++)
            begin
                n1_reg[i]   <= side.neg[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
                prod_reg[i] <= n1_reg[i] * $signed(a_reg[i]);
                n2_reg[i]   <= n1_reg[i];
                n3_reg[i]   <= n2_reg[i];
            end
            deg_reg[0] <= side.degen;
            deg_reg[1] <= deg_reg[0];
            deg_reg[2] <= deg_reg[1];
            p_reg  <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            nx_reg <= deg_reg[2] ? 32'd0 : n3_reg[0];
            ny_reg <= deg_reg[2] ? 32'd0 : n3_reg[1];
            nz_reg <= deg_reg[2] ? 32'd0 : n3_reg[2];
            d_reg  <= deg_reg[2] ? '0 : d_next;
            dg_reg <= deg_reg[2];
        end
    end

    assign out_valid    = vld_reg[3];
    assign normal_x     = nx_reg;
    assign normal_y     = ny_reg;
    assign normal_z     = nz_reg;
    assign plane_offset = d_reg;
    assign degenerate   = dg_reg;

endmodule

>>> hdl/triangle_plane_equation.sv
// Top level of the triangle plane equation pipeline.
// Depends on tpe_pkg, tpe_front, tpe_sqrt, tpe_div, tpe_back.
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z     -
//  m_axis    out  normal_x,normal_y,normal_z,plane_offset degenerate
//
// One triangle per cycle unless the output stalls. In order: front end, square
// root (one root bit per stage), divider (one quotient bit per stage), back end.
// Reset clears the valid bits only. The whole pipeline holds on one enable,
// which drops when a result waits and m_axis_tready is low.
module triangle_plane_equation (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,   // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // normal_x,normal_y,normal_z,plane_offset
    output logic         m_axis_tuser    // degenerate
);
    import tpe_pkg::*;

    logic           ce;
    tpe_pkg::vert_t va, vb, vc;
    logic           f_valid, s_valid, d_valid;
    wvec_t          f_w, s_w;
    logic [63:0]    f_sum;
    side_t          f_side, s_side, d_side;
    logic [31:0]    s_root;
    qvec_t          d_q;
    logic [31:0]    nx, ny, nz;
    logic [39:0]    d;

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign va[i] = s_axis_tdata[i*32 +: 32];
        assign vb[i] = s_axis_tdata[96 + i*32 +: 32];
        assign vc[i] = s_axis_tdata[192 + i*32 +: 32];
    end

    tpe_front u_front (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(s_axis_tvalid),
        .va(va), .vb(vb), .vc(vc),
        .out_valid(f_valid), .w(f_w), .sumsq(f_sum), .side(f_side)
    );

    tpe_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(f_valid),
        .sumsq(f_sum), .in_w(f_w), .in_side(f_side),
        .out_valid(s_valid), .root(s_root), .out_w(s_w), .out_side(s_side)
    );

    tpe_div u_div (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(s_valid),
        .len(s_root), .w(s_w), .in_side(s_side),
        .out_valid(d_valid), .q(d_q), .out_side(d_side)
    );

    tpe_back u_back (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_valid(d_valid),
        .q(d_q), .side(d_side),
        .out_valid(m_axis_tvalid), .normal_x(nx), .normal_y(ny), .normal_z(nz),
        .plane_offset(d), .degenerate(m_axis_tuser)
    );

    assign m_axis_tdata = {d, nz, ny, nx};

endmodule

>>> hdl/tpe_check.sv
// Port-level checks for triangle_plane_equation, bound to the top level.
// Depends on triangle_plane_equation ports only.
module tpe_check (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [287:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output transfer dropped while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 136'd0)
        else $error("degenerate result with nonzero fields");

    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |->
        ($signed(m_axis_tdata[31:0]) <= 32'sd1073741824)
        && ($signed(m_axis_tdata[31:0]) >= -32'sd1073741824)
        && ($signed(m_axis_tdata[95:64]) <= 32'sd1073741824)
        && ($signed(m_axis_tdata[95:64]) >= -32'sd1073741824))
        else $error("normal component out of unit range");

endmodule

bind triangle_plane_equation tpe_check u_tpe_check (.*);
